// ----- design/lavm_pkg.sv -----
// Shared widths, pipeline payload types and a small arithmetic helper for the look-at block.
package lavm_pkg;

  localparam int unsigned CoordWidthDefault = 32;
  localparam int unsigned AxisWidth = 16;
  localparam int unsigned NormWidth = 31;   // magnitude window [2^29, 2^30) plus sign room
  localparam int unsigned SqWidth = 62;
  localparam int unsigned RootWidth = 31;
  localparam int unsigned OneQ14 = 16384;

  typedef logic signed [AxisWidth-1:0] axis_t;
  typedef axis_t vec_t [3];

  // Clamp a signed value to [-1.0, 1.0] in Q1.14.
  function automatic axis_t clamp_unit(input logic signed [31:0] x);
    axis_t r;
    r = x[AxisWidth-1:0];
    if (x > 32'sd16384) begin
      r = 16'sd16384;
    end else if (x < -32'sd16384) begin
      r = -16'sd16384;
    end
    return r;
  endfunction

endpackage

// ----- design/lavm_norm.sv -----
// Pipelined vector normalizer: scale to a fixed window, square root, then per-lane division.
module lavm_norm
  import lavm_pkg::*;
#(
  parameter int unsigned InWidth = 49
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [InWidth-1:0]  vec_i [3],
  output logic                       valid_o,
  output logic                       zero_o,
  output axis_t                      unit_o [3]
);

  localparam int unsigned MagWidth = InWidth;
  localparam int unsigned ShWidth = $clog2(MagWidth + 32);
  // Root iterations: one result bit per step over the 62-bit square sum.
  localparam int unsigned RootSteps = RootWidth;
  // Quotient lanes: 16 bits of quotient (m*16384/L is at most 2^14, plus half).
  localparam int unsigned QuoBits = 16;

  logic [MagWidth-1:0] mag [3];
  logic [MagWidth-1:0] big;
  logic [ShWidth-1:0]  lead;
  logic [NormWidth-1:0] sc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_i[i][InWidth-1] ? MagWidth'(-vec_i[i]) : MagWidth'(vec_i[i]);
    end
    big = mag[0] | mag[1] | mag[2];
    lead = '0;
    for (int b = 0; b < MagWidth; b++) begin
      if (big[b]) lead = ShWidth'(b);
    end
  end

  // Stage 1: window scaling (the highest set bit of the OR equals that of the max).
  logic             s1_valid_q;
  logic             s1_zero_q;
  logic [2:0]       s1_neg_q;
  logic [NormWidth-1:0] s1_m_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead >= ShWidth'(29)) begin
        sc[i] = NormWidth'(mag[i] >> (lead - ShWidth'(29)));
      end else begin
        // Below the window every magnitude is under 2^29, so widening first is exact.
        sc[i] = NormWidth'(mag[i]) << (ShWidth'(29) - lead);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_zero_q <= (big == '0);
      for (int i = 0; i < 3; i++) begin
        s1_neg_q[i] <= vec_i[i][InWidth-1];
        s1_m_q[i]   <= sc[i];
      end
    end
  end

  // Stage 2: squares, one multiplier per lane.
  logic             s2_valid_q;
  logic             s2_zero_q;
  logic [2:0]       s2_neg_q;
  logic [NormWidth-1:0] s2_m_q [3];
  logic [SqWidth-1:0]   s2_sq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_zero_q <= s1_zero_q;
      s2_neg_q  <= s1_neg_q;
      for (int i = 0; i < 3; i++) begin
        s2_m_q[i]  <= s1_m_q[i];
        s2_sq_q[i] <= SqWidth'(s1_m_q[i]) * SqWidth'(s1_m_q[i]);
      end
    end
  end

  // Square root pipeline, one result bit per stage. Stage 0 holds the summed radicand.
  logic             rt_zero_q [RootSteps+1];
  logic [2:0]       rt_neg_q [RootSteps+1];
  logic [NormWidth-1:0] rt_m_q [RootSteps+1][3];
  logic [SqWidth+1:0]   rt_rem_q [RootSteps+1];
  logic [RootWidth-1:0] rt_root_q [RootSteps+1];
  logic [RootSteps:0]   rt_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v_q <= '0;
    end else if (en_i) begin
      rt_v_q <= {rt_v_q[RootSteps-1:0], s2_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rt_zero_q[0] <= s2_zero_q;
      rt_neg_q[0]  <= s2_neg_q;
      rt_m_q[0]    <= s2_m_q;
      rt_rem_q[0]  <= (SqWidth+2)'(s2_sq_q[0]) + (SqWidth+2)'(s2_sq_q[1])
                      + (SqWidth+2)'(s2_sq_q[2]);
      rt_root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam int unsigned Bit = RootSteps - 1 - k;
    logic [SqWidth+1:0] trial;
    logic [SqWidth+1:0] rem_n;
    logic [RootWidth-1:0] root_n;
    always_comb begin
      // Compare remainder with (2*root*2^Bit + 2^(2*Bit)).
      trial = ((SqWidth+2)'(rt_root_q[k]) << (Bit + 1)) | ((SqWidth+2)'(1) << (2 * Bit));
      if (rt_rem_q[k] >= trial) begin
        rem_n  = rt_rem_q[k] - trial;
        root_n = rt_root_q[k] | (RootWidth'(1) << Bit);
      end else begin
        rem_n  = rt_rem_q[k];
        root_n = rt_root_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_zero_q[k+1] <= rt_zero_q[k];
        rt_neg_q[k+1]  <= rt_neg_q[k];
        rt_m_q[k+1]    <= rt_m_q[k];
        rt_rem_q[k+1]  <= rem_n;
        rt_root_q[k+1] <= root_n;
      end
    end
  end

  // Division pipeline: (m*16384 + L/2) / L, restoring, one quotient bit per stage.
  localparam int unsigned NumWidth = NormWidth + 15;
  logic [QuoBits:0]     dv_v_q;
  logic                 dv_zero_q [QuoBits+1];
  logic [2:0]           dv_neg_q [QuoBits+1];
  logic [RootWidth-1:0] dv_den_q [QuoBits+1];
  logic [NumWidth:0]    dv_rem_q [QuoBits+1][3];
  logic [QuoBits-1:0]   dv_quo_q [QuoBits+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q <= '0;
    end else if (en_i) begin
      dv_v_q <= {dv_v_q[QuoBits-1:0], rt_v_q[RootSteps]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_zero_q[0] <= rt_zero_q[RootSteps];
      dv_neg_q[0]  <= rt_neg_q[RootSteps];
      dv_den_q[0]  <= rt_root_q[RootSteps];
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= ((NumWidth+1)'(rt_m_q[RootSteps][i]) << 14)
                          + (NumWidth+1)'(rt_root_q[RootSteps] >> 1);
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int unsigned Bit = QuoBits - 1 - k;
    logic [NumWidth:0]  rem_n [3];
    logic [QuoBits-1:0] quo_n [3];
    logic [NumWidth+QuoBits:0] dsh;
    always_comb begin
      dsh = (NumWidth+QuoBits+1)'(dv_den_q[k]) << Bit;
      for (int i = 0; i < 3; i++) begin
        if ((NumWidth+QuoBits+1)'(dv_rem_q[k][i]) >= dsh) begin
          rem_n[i] = dv_rem_q[k][i] - (NumWidth+1)'(dsh);
          quo_n[i] = dv_quo_q[k][i] | (QuoBits'(1) << Bit);
        end else begin
          rem_n[i] = dv_rem_q[k][i];
          quo_n[i] = dv_quo_q[k][i];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_zero_q[k+1] <= dv_zero_q[k];
        dv_neg_q[k+1]  <= dv_neg_q[k];
        dv_den_q[k+1]  <= dv_den_q[k];
        dv_rem_q[k+1]  <= rem_n;
        dv_quo_q[k+1]  <= quo_n;
      end
    end
  end

  assign valid_o = dv_v_q[QuoBits];
  assign zero_o  = dv_zero_q[QuoBits];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[QuoBits]) begin
        unit_o[i] = '0;
      end else if (dv_neg_q[QuoBits][i]) begin
        unit_o[i] = -axis_t'(dv_quo_q[QuoBits][i]);
      end else begin
        unit_o[i] = axis_t'(dv_quo_q[QuoBits][i]);
      end
    end
  end

endmodule

// ----- design/lavm_delay.sv -----
// Enable-gated delay line that carries side payload alongside a pipeline.
module lavm_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Stages = 4
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] tap_q [Stages];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < Stages; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[Stages-1];

endmodule

// ----- design/look_at_view_matrix_top.sv -----
// Top level of the look-at view matrix pipeline.
//
//  channel   | dir | tdata fields (low bit first)
//  s_axis    | in  | eye_x, eye_y, eye_z, target_x, target_y, target_z (COORD_WIDTH each)
//  m_axis    | out | right_x/y/z, camup_x/y/z, back_x/y/z (16 each), shift_x/y/z (COORD_WIDTH)
//
// A beat enters every cycle unless the pipeline halts. The path is two normalizer passes,
// then the cross product stages and the translation dot products.
// The whole pipeline advances as one: it halts only when the output register is full
// and the downstream side does not take it, so a stall loses and repeats no beat.
// Reset clears the valid bits only; payload registers keep whatever they hold.
module look_at_view_matrix_top
  import lavm_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // right_x..z, camup_x..z, back_x..z, shift_x, shift_y, shift_z
  output logic [((144+3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned OutW = ((144+3*CW+7)/8)*8;
  // Normalizer: scaling, squares and radicand registers, root steps, divider setup,
  // then sixteen quotient steps.
  localparam int unsigned NormLat = 3 + RootWidth + 1 + 16;
  localparam int unsigned SumW = CW + 18;

  // Global advance: the output register is empty or being drained.
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic signed [CW-1:0] eye [3];
  logic signed [CW:0]   diff [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye[i]  = s_axis_tdata_i[i*CW +: CW];
      diff[i] = (CW+1)'(eye[i]) - (CW+1)'($signed(s_axis_tdata_i[(i+3)*CW +: CW]));
    end
  end

  // Back axis normalization.
  logic  w_valid, w_zero;
  axis_t w_vec [3];
  lavm_norm #(.InWidth(CW+1)) u_norm_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid_i && en), .vec_i(diff),
    .valid_o(w_valid), .zero_o(w_zero), .unit_o(w_vec)
  );

  logic [3*CW-1:0] eye_d1, eye_d2;
  lavm_delay #(.Width(3*CW), .Stages(NormLat)) u_eye_d1 (
    .clk_i, .en_i(en), .data_i(s_axis_tdata_i[3*CW-1:0]), .data_o(eye_d1)
  );

  // Right axis: normalize (w_z, 0, -w_x).
  logic signed [16:0] cvec [3];
  assign cvec[0] = 17'(w_vec[2]);
  assign cvec[1] = '0;
  assign cvec[2] = -17'(w_vec[0]);

  logic  u_valid, u_zero;
  axis_t u_raw [3];
  lavm_norm #(.InWidth(17)) u_norm_u (
    .clk_i, .rst_ni, .en_i(en), .valid_i(w_valid), .vec_i(cvec),
    .valid_o(u_valid), .zero_o(u_zero), .unit_o(u_raw)
  );

  logic [47:0] w_d;
  lavm_delay #(.Width(48), .Stages(NormLat)) u_w_d (
    .clk_i, .en_i(en), .data_i({w_vec[2], w_vec[1], w_vec[0]}), .data_o(w_d)
  );
  lavm_delay #(.Width(3*CW), .Stages(NormLat)) u_eye_d2 (
    .clk_i, .en_i(en), .data_i(eye_d1), .data_o(eye_d2)
  );

  axis_t u_vec [3], w2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w2[i] = w_d[i*16 +: 16];
    end
    if (u_zero) begin
      u_vec[0] = '0;
      u_vec[1] = '0;
      u_vec[2] = 16'sd16384;
    end else begin
      u_vec = u_raw;
    end
  end

  // Cross product stage A: six products.
  logic c_valid_q, v_valid_q;
  logic signed [31:0] p_q [6];
  axis_t u_c_q [3], w_c_q [3], u_v_q [3], w_v_q [3], v_q [3];
  logic [3*CW-1:0] eye_c_q, eye_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      v_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= u_valid;
      v_valid_q <= c_valid_q;
    end
  end

  function automatic logic signed [31:0] rnd14(input logic signed [31:0] x);
    logic [31:0] m;
    m = x[31] ? 32'(-x) : 32'(x);
    m = (m + 32'd8192) >> 14;
    return x[31] ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= 32'(w2[1]) * 32'(u_vec[2]);
      p_q[1] <= 32'(w2[2]) * 32'(u_vec[1]);
      p_q[2] <= 32'(w2[2]) * 32'(u_vec[0]);
      p_q[3] <= 32'(w2[0]) * 32'(u_vec[2]);
      p_q[4] <= 32'(w2[0]) * 32'(u_vec[1]);
      p_q[5] <= 32'(w2[1]) * 32'(u_vec[0]);
      u_c_q <= u_vec;
      w_c_q <= w2;
      eye_c_q <= eye_d2;
      // Stage B: difference, rounding and clamp.
      v_q[0] <= clamp_unit(rnd14(p_q[0] - p_q[1]));
      v_q[1] <= clamp_unit(rnd14(p_q[2] - p_q[3]));
      v_q[2] <= clamp_unit(rnd14(p_q[4] - p_q[5]));
      u_v_q <= u_c_q;
      w_v_q <= w_c_q;
      eye_v_q <= eye_c_q;
    end
  end

  // Translation: nine products, then sums, then rounding and saturation.
  logic t1_valid_q, t2_valid_q;
  logic signed [CW+15:0] tp_q [3][3];
  logic signed [SumW-1:0] ts_q [3];
  axis_t ax_t1_q [3][3], ax_t2_q [3][3];
  axis_t ax_src [3][3];

  always_comb begin
    ax_src[0] = u_v_q;
    ax_src[1] = v_q;
    ax_src[2] = w_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q <= v_valid_q;
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int e = 0; e < 3; e++) begin
          tp_q[a][e] <= (CW+16)'(ax_src[a][e])
                        * (CW+16)'($signed(eye_v_q[e*CW +: CW]));
        end
        ts_q[a] <= SumW'(tp_q[a][0]) + SumW'(tp_q[a][1]) + SumW'(tp_q[a][2]);
      end
      ax_t1_q <= ax_src;
      ax_t2_q <= ax_t1_q;
    end
  end

  logic signed [CW-1:0] shift [3];
  always_comb begin
    logic [SumW-1:0] m;
    logic signed [SumW-1:0] r;
    for (int a = 0; a < 3; a++) begin
      m = ts_q[a][SumW-1] ? SumW'(-ts_q[a]) : SumW'(ts_q[a]);
      m = (m + SumW'(8192)) >> 14;
      r = ts_q[a][SumW-1] ? $signed(m) : -$signed(m);
      if (r > $signed(SumW'({1'b0, {(CW-1){1'b1}}}))) begin
        shift[a] = {1'b0, {(CW-1){1'b1}}};
      end else if (r < -$signed(SumW'({1'b0, {(CW-1){1'b1}}})) - 1) begin
        shift[a] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        shift[a] = r[CW-1:0];
      end
    end
  end

  logic [OutW-1:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= OutW'({shift[2], shift[1], shift[0],
                      ax_t2_q[2][2], ax_t2_q[2][1], ax_t2_q[2][0],
                      ax_t2_q[1][2], ax_t2_q[1][1], ax_t2_q[1][0],
                      ax_t2_q[0][2], ax_t2_q[0][1], ax_t2_q[0][0]});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // A held result stays put while the consumer stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_q))
    else $error("output beat changed while stalled");

  // The input side is ready exactly when the pipeline may advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready disagrees with pipeline advance");

  // The right axis x component stays within the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(out_q[15:0]) <= 16'sd16384 && $signed(out_q[15:0]) >= -16'sd16384))
    else $error("right_x out of range");

endmodule
